// ===== sv/bfa_pkg.sv =====
// Package: shared types and constants for the bitmap frame allocator.
`timescale 1ns / 1ps
package bfa_pkg;
    localparam int HIGH_PAGES_DEF = 262144;
    localparam int LOW_PAGES_DEF  = 256;
    localparam int PAGE_W  = 20;
    localparam int COUNT_W = 19;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               region_low;
        logic [PAGE_W-1:0]  page_number;
        logic [COUNT_W-1:0] count;
    } bfa_in_t;

    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] alloc_page;
    } bfa_out_t;
endpackage

// ===== sv/bfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/bitmap_frame_allocator.sv =====
// Top level: bitmap first-fit page frame allocator over two word-wide used-maps.
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | bfa_in_t  (cmd, region_low, page_number, count)
//  m_      | out | m_valid / m_ready  | bfa_out_t (ok, alloc_page)
// After reset a clearing pass writes max(HIGH words, LOW words) words, one per cycle;
// no transfer is taken meanwhile. Allocate: each 64-bit map word is read and checked,
// a word that needs bit-level scanning is scanned in eight-bit groups, then each word
// of the marked run is read and written. Free/reserve: each word touched is read and
// written. One command is in flight at a time; a finished result waits in the output
// register while the next command is accepted.
`timescale 1ns / 1ps
module bitmap_frame_allocator #(
    parameter int HIGH_PAGES = bfa_pkg::HIGH_PAGES_DEF,
    parameter int LOW_PAGES  = bfa_pkg::LOW_PAGES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bfa_pkg::bfa_in_t s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output bfa_pkg::bfa_out_t m_payload
);
    import bfa_pkg::*;

    localparam int MAXP = HIGH_PAGES > LOW_PAGES ? HIGH_PAGES : LOW_PAGES;
    localparam int RW   = ($clog2(MAXP) + 1) > 7 ? ($clog2(MAXP) + 1) : 7;
    localparam int WW   = RW - 6;
    localparam int HW   = (HIGH_PAGES + 63) / 64;
    localparam int LW   = (LOW_PAGES + 63) / 64;
    localparam int HAW  = HW > 1 ? $clog2(HW) : 1;
    localparam int LAW  = LW > 1 ? $clog2(LW) : 1;
    localparam int CW   = HW > LW ? HW : LW;

    typedef enum logic [7:0] {
        ST_CLR   = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_SRD   = 8'b0000_0100,
        ST_SWAIT = 8'b0000_1000,
        ST_SBITS = 8'b0001_0000,
        ST_WRD   = 8'b0010_0000,
        ST_WWR   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t              state_reg;
    logic [WW-1:0]       w_reg;
    logic [2:0]          sub_reg;
    logic [63:0]         word_reg;
    logic [COUNT_W-1:0]  run_reg, n_reg;
    logic [RW-1:0]       size_reg, first_reg, last_reg;
    logic [WW-1:0]       lastw_reg;
    logic                sel_low_reg, set_reg, ok_reg, pend_reg;
    logic [RW-1:0]       pend_last_reg;
    logic [PAGE_W-1:0]   ap_reg;
    logic                m_valid_reg;
    bfa_out_t            m_payload_reg;

    logic [63:0] hi_rdata, lo_rdata, rdata, mask, wdata;
    logic        hi_we, lo_we;

    bfa_ram #(.WIDTH(64), .DEPTH(HW)) u_high_map (
        .aclk(aclk), .we(hi_we), .waddr(w_reg[HAW-1:0]), .wdata(wdata),
        .raddr(w_reg[HAW-1:0]), .rdata(hi_rdata)
    );
    bfa_ram #(.WIDTH(64), .DEPTH(LW)) u_low_map (
        .aclk(aclk), .we(lo_we), .waddr(w_reg[LAW-1:0]), .wdata(wdata),
        .raddr(w_reg[LAW-1:0]), .rdata(lo_rdata)
    );

    assign rdata = sel_low_reg ? lo_rdata : hi_rdata;

    // write mask for the current word of the range
    logic [5:0] lo_b, hi_b;
    always_comb begin
        lo_b = (w_reg == first_reg[RW-1:6]) ? first_reg[5:0] : 6'd0;
        hi_b = (w_reg == last_reg[RW-1:6])  ? last_reg[5:0]  : 6'd63;
        mask = ({64{1'b1}} << lo_b) & ({64{1'b1}} >> (6'd63 - hi_b));
    end

    always_comb begin
        if (state_reg == ST_CLR) begin
            wdata = {64{1'b1}};
            hi_we = (w_reg < WW'(HW));
            lo_we = (w_reg < WW'(LW));
        end else begin
            wdata = set_reg ? (rdata | mask) : (rdata & ~mask);
            hi_we = (state_reg == ST_WWR) && !sel_low_reg;
            lo_we = (state_reg == ST_WWR) && sel_low_reg;
        end
    end

    // 8 bits of the held word per cycle
    logic [COUNT_W-1:0] run_v;
    logic               found_v, b;
    logic [RW-1:0]      p, fpos;
    always_comb begin
        run_v   = run_reg;
        found_v = 1'b0;
        fpos    = '0;
        p       = '0;
        b       = 1'b0;
        for (int k = 0; k < 8; k++) begin
            p = {w_reg, sub_reg, 3'(k)};
            b = word_reg[{sub_reg, 3'(k)}] | (p >= size_reg);
            if (!found_v) begin
                if (b) begin
                    run_v = '0;
                end else begin
                    run_v = run_v + 1'b1;
                    if (run_v == n_reg) begin
                        found_v = 1'b1;
                        fpos    = p;
                    end
                end
            end
        end
    end

    logic [RW-1:0] start_v;
    logic [20:0]   ap_v;
    assign start_v = fpos + RW'(1) - RW'(n_reg);
    assign ap_v    = 21'(start_v) + (sel_low_reg ? 21'd0 : 21'(LOW_PAGES));

    // command decode at accept
    logic [20:0] pg21, cn21, end21, idx21, hend21, rest21, low21, high21, size21;
    always_comb begin
        pg21   = {1'b0, s_payload.page_number};
        cn21   = {2'b0, s_payload.count};
        low21  = 21'(LOW_PAGES);
        high21 = 21'(HIGH_PAGES);
        end21  = pg21 + cn21;
        idx21  = pg21 - low21;
        hend21 = idx21 + cn21;
        rest21 = end21 - low21;
        size21 = s_payload.region_low ? low21 : high21;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            w_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR: begin
                    if (w_reg == WW'(CW - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                    w_reg <= w_reg + 1'b1;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        ap_reg <= '0;
                        if (s_payload.cmd == CMD_ALLOC) begin
                            ok_reg      <= 1'b0;
                            pend_reg    <= 1'b0;
                            sel_low_reg <= s_payload.region_low;
                            size_reg    <= RW'(size21);
                            lastw_reg   <= WW'((size21 - 21'd1) >> 6);
                            n_reg       <= s_payload.count;
                            run_reg     <= '0;
                            set_reg     <= 1'b1;
                            w_reg       <= '0;
                            if (cn21 != 21'd0 && cn21 <= size21) begin
                                state_reg <= ST_SRD;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end else if ((s_payload.cmd == CMD_FREE ||
                                      s_payload.cmd == CMD_RESERVE) &&
                                     pg21 != 21'd0 && cn21 != 21'd0) begin
                            set_reg <= (s_payload.cmd == CMD_RESERVE);
                            if (pg21 < low21) begin
                                sel_low_reg <= 1'b1;
                                first_reg   <= RW'(pg21);
                                w_reg       <= WW'(pg21 >> 6);
                                if (end21 <= low21) begin
                                    last_reg  <= RW'(end21 - 21'd1);
                                    ok_reg    <= 1'b1;
                                    pend_reg  <= 1'b0;
                                    state_reg <= ST_WRD;
                                end else if (s_payload.cmd == CMD_RESERVE) begin
                                    last_reg      <= RW'(low21 - 21'd1);
                                    pend_reg      <= (rest21 <= high21);
                                    ok_reg        <= (rest21 <= high21);
                                    pend_last_reg <= RW'(rest21 - 21'd1);
                                    state_reg     <= ST_WRD;
                                end else begin
                                    ok_reg    <= 1'b0;
                                    pend_reg  <= 1'b0;
                                    state_reg <= ST_DONE;
                                end
                            end else if (hend21 <= high21) begin
                                sel_low_reg <= 1'b0;
                                first_reg   <= RW'(idx21);
                                last_reg    <= RW'(hend21 - 21'd1);
                                w_reg       <= WW'(idx21 >> 6);
                                ok_reg      <= 1'b1;
                                pend_reg    <= 1'b0;
                                state_reg   <= ST_WRD;
                            end else begin
                                ok_reg    <= 1'b0;
                                pend_reg  <= 1'b0;
                                state_reg <= ST_DONE;
                            end
                        end else begin
                            ok_reg    <= 1'b0;
                            pend_reg  <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SRD: begin
                    state_reg <= ST_SWAIT;
                end
                ST_SWAIT: begin
                    word_reg <= rdata;
                    sub_reg  <= '0;
                    if (w_reg < size_reg[RW-1:6] && rdata == {64{1'b1}}) begin
                        run_reg <= '0;
                        if (w_reg == lastw_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            w_reg     <= w_reg + 1'b1;
                            state_reg <= ST_SRD;
                        end
                    end else if (w_reg < size_reg[RW-1:6] && rdata == 64'd0 &&
                                 ({1'b0, run_reg} + 20'd64) < {1'b0, n_reg}) begin
                        run_reg <= run_reg + COUNT_W'(64);
                        if (w_reg == lastw_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            w_reg     <= w_reg + 1'b1;
                            state_reg <= ST_SRD;
                        end
                    end else begin
                        state_reg <= ST_SBITS;
                    end
                end
                ST_SBITS: begin
                    run_reg <= run_v;
                    sub_reg <= sub_reg + 1'b1;
                    if (found_v) begin
                        ok_reg    <= 1'b1;
                        ap_reg    <= ap_v[PAGE_W-1:0];
                        first_reg <= start_v;
                        last_reg  <= fpos;
                        w_reg     <= start_v[RW-1:6];
                        state_reg <= ST_WRD;
                    end else if (sub_reg == 3'd7) begin
                        if (w_reg == lastw_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            w_reg     <= w_reg + 1'b1;
                            state_reg <= ST_SRD;
                        end
                    end
                end
                ST_WRD: begin
                    state_reg <= ST_WWR;
                end
                ST_WWR: begin
                    if (w_reg == last_reg[RW-1:6]) begin
                        if (pend_reg) begin
                            pend_reg    <= 1'b0;
                            sel_low_reg <= 1'b0;
                            first_reg   <= '0;
                            last_reg    <= pend_last_reg;
                            w_reg       <= '0;
                            state_reg   <= ST_WRD;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= ST_WRD;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg              <= 1'b1;
                        m_payload_reg.ok         <= ok_reg;
                        m_payload_reg.alloc_page <= ap_reg;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== sv/bfa_checker.sv =====
// Checker: port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps
module bfa_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input bfa_pkg::bfa_out_t m_payload
);
    import bfa_pkg::*;

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    a_page_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.alloc_page != '0 |-> m_payload.ok)
        else $error("page reported on failed transfer");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command taken while busy");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("channels active right after reset");
endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
);

// ===== tb/bfa_checker.sv =====
// Checker: watches both channels, predicts allocator results and compares them.
`timescale 1ns / 1ps
module bfa_scoreboard
    import bfa_pkg::*;
#(
    parameter int HIGH_PAGES = HIGH_PAGES_DEF,
    parameter int LOW_PAGES  = LOW_PAGES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  bfa_in_t  s_payload,
    input  logic     m_valid,
    input  logic     m_ready,
    input  bfa_out_t m_payload,
    output int       mismatches,
    output int       pending
);
    bit low_map [LOW_PAGES];
    bit high_map[HIGH_PAGES];
    bfa_out_t expected_q[$];

    function automatic void clear_maps();
        foreach (low_map[i]) low_map[i] = 1'b1;
        foreach (high_map[i]) high_map[i] = 1'b1;
    endfunction

    function automatic void mark(bit lo, longint first, longint n, bit used);
        for (longint i = first; i < first + n; i++) begin
            if (lo) low_map[i] = used;
            else high_map[i] = used;
        end
    endfunction

    function automatic bfa_out_t predict(bfa_in_t t);
        bfa_out_t r;
        longint size, run, start, idx, rest, lc;
        longint page, cnt;
        bit go;
        r     = '0;
        page  = t.page_number;
        cnt   = t.count;
        start = -1;
        case (t.cmd)
            CMD_ALLOC: begin
                size = t.region_low ? LOW_PAGES : HIGH_PAGES;
                if (cnt != 0 && cnt <= size) begin
                    run = 0;
                    for (longint i = 0; i < size && start < 0; i++) begin
                        if (!(t.region_low ? low_map[i] : high_map[i])) begin
                            run++;
                            if (run == cnt) start = i + 1 - cnt;
                        end else begin
                            run = 0;
                        end
                    end
                    if (start >= 0) begin
                        mark(t.region_low, start, cnt, 1'b1);
                        r.ok = 1'b1;
                        r.alloc_page = PAGE_W'(t.region_low ? start : start + LOW_PAGES);
                    end
                end
            end
            CMD_FREE: begin
                if (page != 0 && cnt != 0) begin
                    if (page < LOW_PAGES) begin
                        if (page + cnt <= LOW_PAGES) begin
                            mark(1'b1, page, cnt, 1'b0);
                            r.ok = 1'b1;
                        end
                    end else if (page - LOW_PAGES + cnt <= HIGH_PAGES) begin
                        mark(1'b0, page - LOW_PAGES, cnt, 1'b0);
                        r.ok = 1'b1;
                    end
                end
            end
            CMD_RESERVE: begin
                if (page != 0 && cnt != 0) begin
                    go   = 1'b1;
                    rest = cnt;
                    idx  = 0;
                    if (page < LOW_PAGES) begin
                        if (page + cnt <= LOW_PAGES) begin
                            mark(1'b1, page, cnt, 1'b1);
                            r.ok = 1'b1;
                            go   = 1'b0;
                        end else begin
                            lc = LOW_PAGES - page;
                            mark(1'b1, page, lc, 1'b1);
                            rest = cnt - lc;
                        end
                    end else begin
                        idx = page - LOW_PAGES;
                    end
                    if (go && idx + rest <= HIGH_PAGES) begin
                        mark(1'b0, idx, rest, 1'b1);
                        r.ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    initial clear_maps();

    always @(posedge aclk) begin
        bfa_out_t exp_r;
        if (!aresetn) begin
            clear_maps();
            expected_q.delete();
        end else begin
            if (s_valid && s_ready) expected_q.push_back(predict(s_payload));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: ok=%0b page=%0d",
                                 m_payload.ok, m_payload.alloc_page);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_payload.ok !== exp_r.ok
                            || m_payload.alloc_page !== exp_r.alloc_page) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp ok=%0b page=%0d, got ok=%0b page=%0d",
                                     exp_r.ok, exp_r.alloc_page,
                                     m_payload.ok, m_payload.alloc_page);
                    end
                end
            end
        end
        pending <= expected_q.size();
    end
endmodule

// ===== tb/tb_bitmap_frame_allocator.sv =====
// Testbench top: drives allocator commands and reports the verdict.
`timescale 1ns / 1ps
module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    localparam int  LOW  = LOW_PAGES_DEF;
    localparam int  HIGH = HIGH_PAGES_DEF;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bfa_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bfa_out_t m_payload;
    int       mismatches, pending;

    int       send_idle = 30;
    int       recv_idle = 84;
    int       sent = 0;
    longint   cycles = 0;

    always #5 aclk = ~aclk;

    bitmap_frame_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    bfa_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .mismatches(mismatches), .pending(pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver, with one long hold-off once 110 commands have been sent
    initial begin
        int hold;
        bit held;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && sent >= 110) begin
                held = 1'b1;
                for (hold = 0; hold < 20000; hold++) begin
                    m_ready = 1'b0;
                    @(negedge aclk);
                end
            end
            m_ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_cmd(logic [1:0] cmd, logic lo, logic [19:0] page, logic [18:0] cnt);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_payload.cmd = cmd;
        s_payload.region_low = lo;
        s_payload.page_number = page;
        s_payload.count = cnt;
        do @(posedge aclk); while (!s_ready);
        sent++;
        @(negedge aclk);
    endtask

    initial begin
        int r, pg;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_cmd(CMD_NOP, 1'b1, 20'hFFFFF, 19'h7FFFF);
        send_cmd(CMD_ALLOC, 1'b1, 20'd0, 19'd0);
        send_cmd(CMD_ALLOC, 1'b1, 20'd0, 19'(LOW + 1));
        send_cmd(CMD_ALLOC, 1'b0, 20'd0, 19'h7FFFF);
        send_cmd(CMD_ALLOC, 1'b1, 20'd0, 19'd1);
        send_cmd(CMD_FREE, 1'b0, 20'd0, 19'd4);
        send_cmd(CMD_FREE, 1'b0, 20'd5, 19'd0);
        send_cmd(CMD_FREE, 1'b0, 20'd1, 19'(LOW - 1));
        send_cmd(CMD_FREE, 1'b0, 20'd200, 19'd100);
        send_cmd(CMD_ALLOC, 1'b1, 20'd0, 19'd1);
        send_cmd(CMD_ALLOC, 1'b1, 20'd0, 19'd255);
        send_cmd(CMD_RESERVE, 1'b0, 20'd10, 19'd5);
        send_cmd(CMD_FREE, 1'b0, 20'(LOW), 19'd1024);
        send_cmd(CMD_ALLOC, 1'b0, 20'd0, 19'd16);
        send_cmd(CMD_RESERVE, 1'b0, 20'd250, 19'd20);
        send_cmd(CMD_RESERVE, 1'b0, 20'd255, 19'h7FFFF);
        send_cmd(CMD_RESERVE, 1'b1, 20'hFFFFF, 19'd1);
        send_cmd(CMD_FREE, 1'b1, 20'hFFFFF, 19'h7FFFF);
        send_cmd(CMD_FREE, 1'b0, 20'(LOW), 19'(HIGH));
        send_cmd(CMD_ALLOC, 1'b0, 20'd0, 19'(HIGH));
        send_cmd(CMD_FREE, 1'b0, 20'(LOW), 19'd4096);
        send_cmd(CMD_FREE, 1'b0, 20'd1, 19'd200);

        for (int n = 0; n < 118; n++) begin
            if (n == 39) begin
                send_idle = 84;
                recv_idle = 30;
            end else if (n == 78) begin
                send_idle = 0;
                recv_idle = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                if ($urandom_range(0, 3) != 0)
                    send_cmd(CMD_ALLOC, 1'b1, 20'($urandom), 19'($urandom_range(1, 16)));
                else
                    send_cmd(CMD_ALLOC, 1'b0, 20'($urandom), 19'($urandom_range(1, 64)));
            end else if (r < 65) begin
                if ($urandom_range(0, 1)) begin
                    pg = $urandom_range(1, LOW - 1);
                    send_cmd(CMD_FREE, 1'($urandom), 20'(pg), 19'($urandom_range(1, LOW - pg)));
                end else begin
                    send_cmd(CMD_FREE, 1'($urandom), 20'(LOW + $urandom_range(0, 2047)),
                             19'($urandom_range(1, 256)));
                end
            end else if (r < 80) begin
                send_cmd(CMD_RESERVE, 1'($urandom), 20'($urandom_range(1, LOW + 64)),
                         19'($urandom_range(1, 100)));
            end else begin
                send_cmd(2'($urandom), 1'($urandom), 20'($urandom), 19'($urandom));
            end
        end
        s_valid = 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
